>>> rtl/core/three_axis_offset_moving_average_unit_macros.svh
// Assertion macros for the three-axis offset moving average unit.
// Expects clk and arst_n in the scope of use.
`ifndef THREE_AXIS_OFFSET_MOVING_AVERAGE_UNIT_MACROS_SVH
`define THREE_AXIS_OFFSET_MOVING_AVERAGE_UNIT_MACROS_SVH

// Check on every edge out of reset.
`define TAMAV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define TAMAV_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/tamav_pkg.sv
// Shared types and constants of the three-axis offset moving average unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tamav_pkg;

	localparam int AXES       = 3;
	localparam int DATA_W     = 16;
	localparam int SCALED_W   = 13;
	localparam int WINDOW_DEF = 9;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

	typedef logic signed [DATA_W-1:0]   sample_t;
	typedef logic signed [SCALED_W-1:0] scaled_t;
	typedef sample_t [AXES-1:0]         vec_t;
	typedef scaled_t [AXES-1:0]         scaled_vec_t;

	typedef struct packed {
		logic valid;
		vec_t data;
	} item_t;

endpackage

`default_nettype wire

>>> rtl/core/tamav_front.sv
// Front end: offset registers, per-axis offset subtraction with saturation.
// Depends on tamav_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tamav_front
	import tamav_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [DATA_W-1:0]    cfg_wdata,
	input  wire logic                 s_tvalid,
	input  wire vec_t                 s_data,
	output item_t                     push
);

	sample_t                   offset_q [AXES];
	logic signed [DATA_W:0]    diff     [AXES];
	vec_t                      corr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++)
				offset_q[a] <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_OFFSET_X: offset_q[0] <= cfg_wdata;
				REG_OFFSET_Y: offset_q[1] <= cfg_wdata;
				REG_OFFSET_Z: offset_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// saturate the difference to the sample range
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			diff[a] = (DATA_W+1)'(s_data[a]) - (DATA_W+1)'(offset_q[a]);
			if (diff[a][DATA_W] != diff[a][DATA_W-1])
				corr[a] = diff[a][DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
				                          : {1'b0, {(DATA_W-1){1'b1}}};
			else
				corr[a] = diff[a][DATA_W-1:0];
		end
	end

	assign push.valid = s_tvalid;
	assign push.data  = corr;

endmodule

`default_nettype wire

>>> rtl/core/tamav_queue.sv
// Two-entry queue between the front end and the filter back end.
// Depends on tamav_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tamav_queue
	import tamav_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t in_item,
	output logic       in_ready,
	output item_t      out_item,
	input  wire logic  out_ready
);

	vec_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready       = (count_q != 2'd2);
	assign push           = in_item.valid && in_ready;
	assign pop            = out_item.valid && out_ready;
	assign out_item.valid = (count_q != 2'd0);
	assign out_item.data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= in_item.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tamav_back.sv
// Back end: window shift lines, running sums, divide by the window and by ten,
// output register. Depends on tamav_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tamav_back
	import tamav_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t in_item,
	output logic       in_ready,
	output logic       m_tvalid,
	input  wire logic  m_tready,
	output vec_t       mean,
	output scaled_vec_t scaled
);

	localparam int MW = DATA_W + $clog2(WINDOW);
	localparam logic [MW-1:0] D1 = MW'(WINDOW);
	localparam logic [MW-1:0] D2 = MW'(10 * WINDOW);
	localparam logic [MW-1:0] R1 = MW'((64'd1 << MW) / WINDOW);
	localparam logic [MW-1:0] R2 = MW'((64'd1 << MW) / (10 * WINDOW));

	logic                 en;
	logic                 take;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 valid_s3;
	logic                 out_valid_q;
	sample_t              ring_q  [AXES][WINDOW];
	logic signed [MW-1:0] sum_q   [AXES];
	logic                 neg_s2  [AXES];
	logic [MW-1:0]        mag_s2  [AXES];
	logic                 neg_s3  [AXES];
	logic [MW-1:0]        mag_s3  [AXES];
	logic [2*MW-1:0]      p1_s3   [AXES];
	logic [2*MW-1:0]      p2_s3   [AXES];
	logic [MW-1:0]        q1      [AXES];
	logic [MW-1:0]        q2      [AXES];
	logic [MW-1:0]        r1      [AXES];
	logic [MW-1:0]        r2      [AXES];
	logic [MW-1:0]        m1      [AXES];
	logic [MW-1:0]        m2      [AXES];
	logic [MW-1:0]        sm1     [AXES];
	logic [MW-1:0]        sm2     [AXES];
	vec_t                 mean_q;
	scaled_vec_t          scaled_q;

	assign en       = !out_valid_q || m_tready;
	assign in_ready = en;
	assign take     = in_item.valid && en;
	assign m_tvalid = out_valid_q;
	assign mean     = mean_q;
	assign scaled   = scaled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= take;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// shift in the new word, drop the oldest from the running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= '0;
				for (int i = 0; i < WINDOW; i++)
					ring_q[a][i] <= '0;
			end
		end else if (take) begin
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= sum_q[a] - MW'(ring_q[a][WINDOW-1]) + MW'(in_item.data[a]);
				ring_q[a][0] <= in_item.data[a];
				for (int i = 1; i < WINDOW; i++)
					ring_q[a][i] <= ring_q[a][i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				neg_s2[a] <= sum_q[a][MW-1];
				mag_s2[a] <= sum_q[a][MW-1] ? MW'(-sum_q[a]) : MW'(sum_q[a]);
				neg_s3[a] <= neg_s2[a];
				mag_s3[a] <= mag_s2[a];
				p1_s3[a]  <= mag_s2[a] * R1;
				p2_s3[a]  <= mag_s2[a] * R2;
			end
		end
	end

	// reciprocal estimate is low by at most one: correct with one compare
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			q1[a]  = p1_s3[a][2*MW-1:MW];
			q2[a]  = p2_s3[a][2*MW-1:MW];
			r1[a]  = mag_s3[a] - q1[a] * D1;
			r2[a]  = mag_s3[a] - q2[a] * D2;
			m1[a]  = q1[a] + MW'(r1[a] >= D1);
			m2[a]  = q2[a] + MW'(r2[a] >= D2);
			sm1[a] = neg_s3[a] ? -m1[a] : m1[a];
			sm2[a] = neg_s3[a] ? -m2[a] : m2[a];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				mean_q[a]   <= sm1[a][DATA_W-1:0];
				scaled_q[a] <= sm2[a][SCALED_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/three_axis_offset_moving_average_unit.sv
// Path: queue, running sum, divide pipeline (magnitude, product), output register.
// Throughput: one word per cycle unless the output stalls; the output register and
// the two-entry queue let input and output stall independently.
// Reset: arst_n clears offsets, window contents, running sums and all valid state;
// the window starts as zeros and every average divides by the full window.
`timescale 1ns / 1ps
`default_nettype none

module three_axis_offset_moving_average_unit
	import tamav_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [DATA_W-1:0]    cfg_wdata,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// sample_x, sample_y, sample_z
	input  wire logic [47:0]          s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// mean_x, mean_y, mean_z, scaled_x, scaled_y, scaled_z, zero pad
	output logic [87:0]               m_tdata
);

	`include "three_axis_offset_moving_average_unit_macros.svh"

	item_t        push_item;
	item_t        pop_item;
	logic         pop_ready;
	vec_t         mean;
	scaled_vec_t  scaled;
	logic [2:0]   in_flight_q;
	logic         in_acc;
	logic         out_acc;
	sample_t      chk_mean;
	scaled_t      chk_scaled;
	logic signed [17:0] chk_diff;

	tamav_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_data    (vec_t'(s_tdata)),
		.push      (push_item)
	);

	tamav_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (push_item),
		.in_ready  (s_tready),
		.out_item  (pop_item),
		.out_ready (pop_ready)
	);

	tamav_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (pop_item),
		.in_ready (pop_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.mean     (mean),
		.scaled   (scaled)
	);

	assign m_tdata = {1'b0, scaled, mean};

	// words accepted but not yet delivered
	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q <= 3'd0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   in_flight_q <= in_flight_q + 3'd1;
				2'b01:   in_flight_q <= in_flight_q - 3'd1;
				default: in_flight_q <= in_flight_q;
			endcase
		end
	end

	assign chk_mean   = mean[0];
	assign chk_scaled = scaled[0];
	assign chk_diff   = 18'(chk_mean) - 18'(chk_scaled) * 18'sd10;

	`TAMAV_ASSERT(a_in_flight_bound, in_flight_q <= 3'd6, "more words in flight than stages")
	`TAMAV_ASSERT(a_no_phantom, m_tvalid |-> in_flight_q != 3'd0, "result with no word in flight")
	`TAMAV_ASSERT(a_scaled_match, m_tvalid |-> ((!chk_mean[15] && chk_diff >= 0 && chk_diff <= 9) || (chk_mean[15] && chk_diff <= 0 && chk_diff >= -9)), "scaled x is not mean x over ten")
	`TAMAV_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "result valid during reset")

endmodule

`default_nettype wire

>>> bench/tamav_average_checker.sv
// Checker for the three-axis offset moving average unit: watches the config port and both streams,
// predicts every average word and compares it field by field.
// Depends on tamav_pkg.
`timescale 1ns / 1ps

module tamav_average_checker
	import tamav_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [DATA_W-1:0]    cfg_wdata,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	// sample_x, sample_y, sample_z
	input  wire logic [47:0]          s_tdata,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	// mean_x, mean_y, mean_z, scaled_x, scaled_y, scaled_z, zero pad
	input  wire logic [87:0]          m_tdata,
	output int                        errors,
	output int                        pending,
	output int                        checked
);

	typedef struct {
		sample_t mean [AXES];
		scaled_t scaled [AXES];
	} avg_word_t;

	sample_t   offs [AXES];
	int        window_mem [AXES][WINDOW_DEF];
	int        acc [AXES];
	int        slot;
	avg_word_t expected_means [$];

	function automatic avg_word_t absorb_word(input logic [47:0] w);
		avg_word_t r;
		int        d;
		int        m;
		for (int ax = 0; ax < AXES; ax++) begin
			d = int'(sample_t'(w[ax*DATA_W +: DATA_W])) - int'(offs[ax]);
			if (d > 32767)
				d = 32767;
			else if (d < -32768)
				d = -32768;
			acc[ax] = acc[ax] - window_mem[ax][slot] + d;
			window_mem[ax][slot] = d;
			m = acc[ax] / WINDOW_DEF;
			r.mean[ax] = sample_t'(m);
			r.scaled[ax] = scaled_t'(m / 10);
		end
		slot = (slot == WINDOW_DEF - 1) ? 0 : slot + 1;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_word(input logic [87:0] w);
		avg_word_t want;
		sample_t   got_mean;
		scaled_t   got_scaled;
		if (expected_means.size() == 0) begin
			report_mismatch("average word with no sample outstanding");
			return;
		end
		want = expected_means.pop_front();
		for (int ax = 0; ax < AXES; ax++) begin
			got_mean = w[ax*DATA_W +: DATA_W];
			got_scaled = w[AXES*DATA_W + ax*SCALED_W +: SCALED_W];
			if (got_mean !== want.mean[ax])
				report_mismatch($sformatf("word %0d mean axis %0d: got %0d, want %0d",
					checked, ax, got_mean, want.mean[ax]));
			if (got_scaled !== want.scaled[ax])
				report_mismatch($sformatf("word %0d scaled axis %0d: got %0d, want %0d",
					checked, ax, got_scaled, want.scaled[ax]));
		end
		if (w[87] !== 1'b0)
			report_mismatch($sformatf("word %0d: pad bit set", checked));
		checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ax = 0; ax < AXES; ax++) begin
				offs[ax] = '0;
				acc[ax] = 0;
				for (int i = 0; i < WINDOW_DEF; i++)
					window_mem[ax][i] = 0;
			end
			slot = 0;
			expected_means.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_OFFSET_X: offs[0] = cfg_wdata;
					REG_OFFSET_Y: offs[1] = cfg_wdata;
					REG_OFFSET_Z: offs[2] = cfg_wdata;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_word(m_tdata);
			if (s_tvalid && s_tready)
				expected_means.push_back(absorb_word(s_tdata));
			pending <= expected_means.size();
		end
	end

endmodule

>>> bench/three_axis_offset_moving_average_unit_test.sv
// Testbench top for the three-axis offset moving average unit: drives samples, offsets
// and output back-pressure, and gives the verdict. Depends on tamav_pkg and tamav_average_checker.
`timescale 1ns / 1ps

module three_axis_offset_moving_average_unit_test;
	import tamav_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PHASE_WORDS = 335;
	localparam int CYCLE_LIMIT = 300000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b1;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [DATA_W-1:0]    cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [47:0]          s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [87:0]          m_tdata;

	int      errors;
	int      pending;
	int      checked;
	int      gap_pct = 0;
	int      stall_pct = 0;
	int      words_sent = 0;
	int      cfg_writes = 0;
	int      cycles = 0;
	sample_t cur_off [AXES] = '{default: '0};

	three_axis_offset_moving_average_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	tamav_average_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= (int'($urandom_range(99)) >= stall_pct);
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_sample(input sample_t x, input sample_t y, input sample_t z);
		while (int'($urandom_range(99)) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	// hold valid low and wait until every average word is back
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_offsets(input sample_t ox, input sample_t oy, input sample_t oz);
		logic [CFG_IDX_W-1:0] addrs [4];
		logic [DATA_W-1:0]    vals [4];
		addrs = '{REG_UNUSED, REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z};
		vals = '{DATA_W'($urandom), ox, oy, oz};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= addrs[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
			cfg_writes++;
		end
		cfg_we <= 1'b0;
		cur_off = '{ox, oy, oz};
	endtask

	function automatic sample_t pick_sample(input int ax);
		int mode;
		mode = $urandom_range(9);
		case (mode)
			0, 1, 2, 3: return sample_t'($urandom);
			4, 5, 6: return sample_t'(int'(cur_off[ax]) + int'($urandom_range(400)) - 200);
			7: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			8: return sample_t'(int'($urandom_range(40)) - 20);
			default: return $urandom_range(1) ? sample_t'(32767 - int'($urandom_range(15)))
				: sample_t'(-32768 + int'($urandom_range(15)));
		endcase
	endfunction

	initial begin
		int      run;
		int      sent;
		sample_t x, y, z;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill from cleared window, negative truncation, then a full window of extremes
		send_sample(16'sh7fff, 16'sh8000, 16'sd0);
		send_sample(16'sh7fff, 16'sh8000, 16'sd9);
		send_sample(-16'sd1, 16'sd1, -16'sd89);
		send_sample(16'sh8000, 16'sh7fff, 16'sd90);
		repeat (9) send_sample(16'sh7fff, 16'sh8000, -16'sd5);
		settle();

		// saturation of the corrected sample in both directions
		write_offsets(16'sh8000, 16'sh7fff, 16'sd1);
		send_sample(16'sh7fff, 16'sh8000, 16'sd0);
		send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sd100, -16'sd100, 16'sh7fff);
		send_sample(16'sh7fff, 16'sh8000, 16'sh8000);
		settle();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
					write_offsets(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom));
				end
				1: begin
					gap_pct = 83;
					stall_pct = 0;
					write_offsets(16'sh7fff, 16'sh8000, 16'sd0);
				end
				2: begin
					gap_pct = 0;
					stall_pct = 83;
					write_offsets(16'sh8000, 16'sh7fff, sample_t'($urandom));
				end
				default: begin
					gap_pct = 34;
					stall_pct = 34;
					write_offsets(sample_t'($urandom), sample_t'($urandom),
						sample_t'(int'($urandom_range(200)) - 100));
				end
			endcase
			sent = 0;
			while (sent < PHASE_WORDS) begin
				if ($urandom_range(7) == 0) begin
					// steady run long enough to flush the window
					run = 9 + $urandom_range(3);
					x = pick_sample(0);
					y = pick_sample(1);
					z = pick_sample(2);
					repeat (run) send_sample(x, y, z);
					sent += run;
				end else begin
					send_sample(pick_sample(0), pick_sample(1), pick_sample(2));
					sent++;
				end
			end
			settle();
		end

		$display("sent %0d sample words and checked %0d averages over four flow-control phases,",
			words_sent, checked);
		$display("with %0d offset register writes including the unused index", cfg_writes);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> three_axis_offset_moving_average_unit.f
+incdir+rtl/core
rtl/core/tamav_pkg.sv
rtl/core/tamav_front.sv
rtl/core/tamav_queue.sv
rtl/core/tamav_back.sv
rtl/core/three_axis_offset_moving_average_unit.sv
bench/tamav_average_checker.sv
bench/three_axis_offset_moving_average_unit_test.sv
